### rtl/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_PATTERN_BYTES      = 3'd0;
	localparam logic [2:0] REG_PATTERN_LENGTH     = 3'd1;
	localparam logic [2:0] REG_REPLACEMENT_BYTES  = 3'd2;
	localparam logic [2:0] REG_REPLACEMENT_LENGTH = 3'd3;
	localparam logic [2:0] REG_CASE_FOLD          = 3'd4;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned WORD_W   = 64;
	localparam int unsigned LEN_W    = 4;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned REPL_MAX = 8;

	localparam logic [BYTE_W-1:0]  ASCII_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0]  ASCII_UPPER_Z = 8'h5A;
	localparam logic [BYTE_W-1:0]  ASCII_CASE    = 8'h20;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;

	typedef logic [LEN_W-1:0] len_t;

endpackage

`default_nettype wire

### rtl/stream_find_and_replace.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   data                                      side band
// s_*       in    tdata[7:0] text_byte                      tlast end_of_text
// m_*       out   tdata[7:0] out_byte, [23:8] match_count   tuser byte_valid, tlast end_of_output
// cfg_*     in    cfg_index selects register, cfg_wdata     write when cfg_we high
//
// one text byte is taken per cycle; it is matched against the pending window and its
// results (0 to 8 bytes) are loaded into a result burst register in the same cycle.
// the burst register drains one result per cycle, so a byte that yields one result
// sustains one byte per cycle; a longer burst holds s_tready low until its last result goes.
// arst_n clears window fill, match count and the burst; window bytes are not reset.
// stalls on m_tready hold the burst and back-pressure the input side.

module stream_find_and_replace #(
	parameter int MAX_PATTERN = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] match_count
	output logic             m_tuser,   // [0] byte_valid
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_wdata
);

	localparam int WIN = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;

	// configuration
	logic [sfr_pkg::WORD_W-1:0] pattern_q;
	sfr_pkg::len_t              pat_len_q;
	logic [sfr_pkg::WORD_W-1:0] repl_q;
	sfr_pkg::len_t              repl_len_q;
	logic                       fold_q;

	// search state
	logic [sfr_pkg::BYTE_W-1:0]  win_q [WIN];
	sfr_pkg::len_t               fill_q;
	logic [sfr_pkg::COUNT_W-1:0] match_q;

	// result burst
	logic [sfr_pkg::WORD_W-1:0]  burst_q;
	sfr_pkg::len_t               rem_q;
	logic                        bvalid_q;
	logic                        blast_q;
	logic [sfr_pkg::COUNT_W-1:0] bcount_q;

	logic s_fire, m_fire;

	sfr_pkg::len_t               len, rlen, fill_cur, fill_next, nf, emit_n, fill_new;
	logic [sfr_pkg::BYTE_W-1:0]  b;
	logic [sfr_pkg::BYTE_W-1:0]  wn [WIN];
	logic [sfr_pkg::BYTE_W-1:0]  ws [WIN];
	logic [sfr_pkg::WORD_W-1:0]  wpack;
	logic                        full, matched, emit_valid;
	logic [sfr_pkg::COUNT_W-1:0] count_new;

	assign m_tvalid = (rem_q != '0);
	assign s_tready = (rem_q == '0) || (rem_q == sfr_pkg::len_t'(1) && m_tready);
	assign s_fire   = s_tvalid && s_tready;
	assign m_fire   = m_tvalid && m_tready;

	assign m_tdata  = {bcount_q, burst_q[sfr_pkg::BYTE_W-1:0]};
	assign m_tuser  = bvalid_q;
	assign m_tlast  = blast_q && (rem_q == sfr_pkg::len_t'(1));

	always_comb begin
		// effective lengths
		if (pat_len_q == '0)
			len = sfr_pkg::len_t'(1);
		else if (pat_len_q > sfr_pkg::len_t'(WIN))
			len = sfr_pkg::len_t'(WIN);
		else
			len = pat_len_q;
		rlen = (repl_len_q > sfr_pkg::len_t'(sfr_pkg::REPL_MAX)) ?
			sfr_pkg::len_t'(sfr_pkg::REPL_MAX) : repl_len_q;

		b = s_tdata;
		if (fold_q && s_tdata >= sfr_pkg::ASCII_UPPER_A && s_tdata <= sfr_pkg::ASCII_UPPER_Z)
			b = s_tdata + sfr_pkg::ASCII_CASE;

		fill_cur = (fill_q >= len) ? '0 : fill_q;
		nf = fill_cur + sfr_pkg::len_t'(1);
		full = (nf == len);

		wpack = '0;
		matched = full;
		for (int i = 0; i < WIN; i++) begin
			wn[i] = (fill_cur == sfr_pkg::len_t'(i)) ? b : win_q[i];
			wpack[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] = wn[i];
			if (sfr_pkg::len_t'(i) < len && wn[i] != pattern_q[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W])
				matched = 1'b0;
		end
		for (int i = 0; i < WIN; i++)
			ws[i] = (i + 1 < WIN) ? wn[(i + 1) % WIN] : wn[i];

		count_new = (matched && match_q != sfr_pkg::COUNT_MAX) ?
			match_q + sfr_pkg::COUNT_W'(1) : match_q;

		emit_valid = 1'b1;
		priority if (matched) begin
			if (s_tlast && rlen == '0) begin
				emit_n = sfr_pkg::len_t'(1);
				emit_valid = 1'b0;
			end else begin
				emit_n = rlen;
			end
			fill_new = '0;
		end else if (s_tlast) begin
			emit_n = nf;
			fill_new = '0;
		end else if (full) begin
			emit_n = sfr_pkg::len_t'(1);
			fill_new = len - sfr_pkg::len_t'(1);
		end else begin
			emit_n = '0;
			fill_new = nf;
		end

		fill_next = fill_q;
		if (cfg_we && cfg_index == sfr_pkg::REG_PATTERN_LENGTH)
			fill_next = '0;
		else if (s_fire)
			fill_next = fill_new;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q  <= '0;
			pat_len_q  <= sfr_pkg::len_t'(1);
			repl_q     <= '0;
			repl_len_q <= '0;
			fold_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfr_pkg::REG_PATTERN_BYTES:      pattern_q  <= cfg_wdata;
				sfr_pkg::REG_PATTERN_LENGTH:     pat_len_q  <= cfg_wdata[sfr_pkg::LEN_W-1:0];
				sfr_pkg::REG_REPLACEMENT_BYTES:  repl_q     <= cfg_wdata;
				sfr_pkg::REG_REPLACEMENT_LENGTH: repl_len_q <= cfg_wdata[sfr_pkg::LEN_W-1:0];
				sfr_pkg::REG_CASE_FOLD:          fold_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// window bytes
	always_ff @(posedge clk) begin
		if (s_fire) begin
			for (int i = 0; i < WIN; i++)
				win_q[i] <= (!matched && !s_tlast && full) ? ws[i] : wn[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			match_q <= '0;
		end else begin
			fill_q <= fill_next;
			if (s_fire)
				match_q <= s_tlast ? '0 : count_new;
		end
	end

	// result burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (s_fire) begin
			rem_q <= emit_n;
		end else if (m_fire) begin
			rem_q <= rem_q - sfr_pkg::len_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			// the empty end marker carries a zero byte
			burst_q  <= matched ? (emit_valid ? repl_q : '0) : wpack;
			bvalid_q <= emit_valid;
			blast_q  <= s_tlast;
			bcount_q <= count_new;
		end else if (m_fire) begin
			burst_q <= burst_q >> sfr_pkg::BYTE_W;
		end
	end

	a_fill_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < len)
		else $error("window fill reached pattern length");

	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= sfr_pkg::len_t'(sfr_pkg::REPL_MAX))
		else $error("result burst longer than eight");

	a_text_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_tlast |=> fill_q == '0 && match_q == '0)
		else $error("state not cleared after end of text");

	a_end_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("empty result that is not the last");

	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q > sfr_pkg::len_t'(1) |-> !s_tready)
		else $error("request taken while burst pending");

endmodule

`default_nettype wire
